// ----- hw/rtl/nsr_pkg.sv -----
// nsr_pkg: shared constants and widths for the newton square root block
// no dependencies; imported by nsr_div and newton_square_root
`default_nettype none

package nsr_pkg;

  localparam int VALUE_W       = 32;
  localparam int TOL_W         = 16;
  localparam int FRAC_BITS_DEF = 16;
  localparam int MAX_ITER_DEF  = 64;

  localparam logic [TOL_W-1:0] TOL_RESET = 16'd7;

endpackage

`default_nettype wire

// ----- hw/rtl/nsr_div.sv -----
// nsr_div: restoring unsigned divider, one quotient bit per cycle
// depends on nsr_pkg for the default operand width
`default_nettype none

module nsr_div #(
  parameter int W = nsr_pkg::VALUE_W + nsr_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);
  import nsr_pkg::*;

  localparam int CW = $clog2(W + 1);

  logic          running;
  logic [CW-1:0] cnt;
  logic [W:0]    rem;
  logic [W-1:0]  quo;
  logic [W:0]    rem_sh;
  logic [W:0]    div_ext;
  logic          ge;

  assign rem_sh   = {rem[W-1:0], quo[W-1]};
  assign div_ext  = {1'b0, divisor};
  assign ge       = (rem_sh >= div_ext);
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CW'(W);
        rem     <= '0;
        quo     <= dividend;
      end else if (running) begin
        rem <= ge ? (rem_sh - div_ext) : rem_sh;
        quo <= {quo[W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // remainder always stays below the divisor between steps
  a_rem_below_div : assert property (@(posedge clk) disable iff (rst)
    (running && !$past(start)) |-> (rem < div_ext))
    else $error("divider remainder not below divisor");

  a_done_after_run : assert property (@(posedge clk) disable iff (rst)
    done |-> !running)
    else $error("divider done while still running");

  a_start_idle : assert property (@(posedge clk) disable iff (rst)
    start |-> !running)
    else $error("divider started while running");

endmodule

`default_nettype wire

// ----- hw/rtl/newton_square_root.sv -----
// newton_square_root: Q-format square root by Newton iteration over a shared divider
// depends on nsr_pkg and nsr_div
// sequence: each pass runs the bit-serial divider over W = 32 + FRAC_BITS bits,
//   then the mean and check states; up to MAX_ITER passes before the result is shown
// throughput: one item at a time; busy stays high until done, and a new start is
//   taken in the cycle the result is shown; done is a one-cycle strobe, never stalled
// reset: synchronous, clears sequencer and strobe, tolerance returns to 7 LSB
`default_nettype none

module newton_square_root #(
  parameter int FRAC_BITS = nsr_pkg::FRAC_BITS_DEF,
  parameter int MAX_ITER  = nsr_pkg::MAX_ITER_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [nsr_pkg::VALUE_W-1:0] value,
  input  logic                        tolerance_write,
  input  logic [nsr_pkg::TOL_W-1:0]   tolerance,
  output logic                        done,
  output logic [nsr_pkg::VALUE_W-1:0] root,
  output logic                        hit_limit
);
  import nsr_pkg::*;

  localparam int NUM_W  = VALUE_W + FRAC_BITS;
  localparam int PASS_W = $clog2(MAX_ITER);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_MEAN,
    S_CHECK
  } state_t;

  state_t             state;
  logic [TOL_W-1:0]   tol;
  logic [NUM_W-1:0]   num;
  logic [NUM_W-1:0]   guess;
  logic [NUM_W-1:0]   mean;
  logic [PASS_W-1:0]  passes;
  logic               div_start;
  logic               div_done;
  logic [NUM_W-1:0]   quot;

  logic [NUM_W:0]     sum;
  logic [NUM_W-1:0]   diff;
  logic               conv;
  logic [VALUE_W-1:0] root_sat;

  assign busy = (state != S_IDLE);
  assign sum  = {1'b0, quot} + {1'b0, guess};
  assign diff = (mean >= guess) ? (mean - guess) : (guess - mean);
  assign conv = (diff < NUM_W'(tol)) || (mean == '0);
  assign root_sat = (|mean[NUM_W-1:VALUE_W]) ? '1 : mean[VALUE_W-1:0];

  nsr_div #(
    .W(NUM_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (num),
    .divisor  (guess),
    .done     (div_done),
    .quotient (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TOL_RESET;
    end else if (tolerance_write) begin
      tol <= tolerance;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_start <= 1'b0;
      done      <= 1'b0;
      passes    <= '0;
    end else begin
      div_start <= 1'b0;
      done      <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            num       <= {value, FRAC_BITS'(0)};
            guess     <= NUM_W'(1) << FRAC_BITS;
            passes    <= '0;
            div_start <= 1'b1;
            state     <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_MEAN;
          end
        end
        S_MEAN: begin
          mean  <= sum[NUM_W:1];
          state <= S_CHECK;
        end
        S_CHECK: begin
          guess <= mean;
          if (conv || passes == PASS_W'(MAX_ITER - 1)) begin
            done      <= 1'b1;
            root      <= root_sat;
            hit_limit <= !conv;
            state     <= S_IDLE;
          end else begin
            passes    <= passes + 1'b1;
            div_start <= 1'b1;
            state     <= S_DIV;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result transfer closes every item
  a_fall_done : assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy dropped without result transfer");

  a_accept_busy : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && div_start))
    else $error("accepted item did not launch division");

  a_divide_nonzero : assert property (@(posedge clk) disable iff (rst)
    div_start |-> (guess != '0))
    else $error("division launched with zero guess");

  a_done_idle : assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy && !div_start))
    else $error("result shown while still working");

endmodule

`default_nettype wire

// ----- test/tb_newton_square_root.sv -----
// tb_newton_square_root: self-checking testbench for the newton square root block
// depends on nsr_pkg and newton_square_root; holds its own fixed-point root predictor
// checks root and hit_limit of every result over several tolerance settings
`timescale 1ns / 1ps

class sqrt_checker;
  bit [nsr_pkg::TOL_W-1:0]   tol;
  bit [nsr_pkg::VALUE_W-1:0] expected_roots[$];
  bit                        expected_limits[$];
  int                        failures;

  function new();
    tol      = nsr_pkg::TOL_RESET;
    failures = 0;
  endfunction

  function void set_tolerance(bit [nsr_pkg::TOL_W-1:0] t);
    tol = t;
  endfunction

  function int pending();
    return expected_roots.size();
  endfunction

  // heron iteration on the widened operand, guess starts at 1.0
  function void predict_root(input bit [nsr_pkg::VALUE_W-1:0] v,
                             output bit [nsr_pkg::VALUE_W-1:0] r, output bit capped);
    bit [63:0] num;
    bit [63:0] guess;
    bit [63:0] quot;
    bit [63:0] mean;
    bit [63:0] diff;
    num    = {32'd0, v} << nsr_pkg::FRAC_BITS_DEF;
    guess  = 64'd1 << nsr_pkg::FRAC_BITS_DEF;
    capped = 1'b1;
    for (int pass = 0; pass < nsr_pkg::MAX_ITER_DEF; pass++) begin
      quot  = num / guess;
      mean  = (quot >> 1) + (guess >> 1) + {63'd0, quot[0] & guess[0]};
      diff  = (mean >= guess) ? mean - guess : guess - mean;
      guess = mean;
      if (diff < {48'd0, tol} || guess == 64'd0) begin
        capped = 1'b0;
        break;
      end
    end
    r = (guess > 64'hFFFF_FFFF) ? '1 : guess[31:0];
  endfunction

  function void note_operand(bit [nsr_pkg::VALUE_W-1:0] v);
    bit [nsr_pkg::VALUE_W-1:0] r;
    bit                        capped;
    predict_root(v, r, capped);
    expected_roots.push_back(r);
    expected_limits.push_back(capped);
  endfunction

  function void check_root(bit [nsr_pkg::VALUE_W-1:0] r, bit capped);
    bit [nsr_pkg::VALUE_W-1:0] exp_r;
    bit                        exp_c;
    if (expected_roots.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("unexpected result: root=%h hit_limit=%0b", r, capped);
      return;
    end
    exp_r = expected_roots.pop_front();
    exp_c = expected_limits.pop_front();
    if (r !== exp_r || capped !== exp_c) begin
      failures++;
      if (failures <= 10)
        $display("mismatch: root exp=%h got=%h  hit_limit exp=%0b got=%0b",
                 exp_r, r, exp_c, capped);
    end
  endfunction

  function void finish();
    failures += expected_roots.size();
  endfunction
endclass

module tb_newton_square_root;
  localparam int WATCHDOG_LIMIT = 20000;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        start = 1'b0;
  logic                        busy;
  logic [nsr_pkg::VALUE_W-1:0] value = '0;
  logic                        tolerance_write = 1'b0;
  logic [nsr_pkg::TOL_W-1:0]   tolerance = '0;
  logic                        done;
  logic [nsr_pkg::VALUE_W-1:0] root;
  logic                        hit_limit;

  sqrt_checker sb = new();
  bit          quiet = 1'b0;
  int          stall_cycles = 0;

  newton_square_root u_top (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .value           (value),
    .tolerance_write (tolerance_write),
    .tolerance       (tolerance),
    .done            (done),
    .root            (root),
    .hit_limit       (hit_limit)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done === 1'b1)
      sb.check_root(root, hit_limit);
    if ((!rst && done === 1'b1) || (start && busy === 1'b0))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic bit [31:0] random_operand();
    bit [15:0] k;
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 32'h0000_FFFF);
      2: return $urandom_range(0, 32'h00FF_FFFF);
      default: begin
        k = $urandom_range(0, 16'hFFFF);
        return k * k + $urandom_range(0, 2) - 1;
      end
    endcase
  endfunction

  task automatic transfer_operand(input bit [31:0] v);
    while (!quiet && $urandom_range(0, 99) < 27) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    value <= v;
    do @(posedge clk); while (busy);
    sb.note_operand(v);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (sb.pending() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_tolerance(input bit [15:0] t);
    wait_drained();
    tolerance_write <= 1'b1;
    tolerance       <= t;
    @(posedge clk);
    tolerance_write <= 1'b0;
    sb.set_tolerance(t);
  endtask

  task automatic random_burst(input int count);
    repeat (count) transfer_operand(random_operand());
  endtask

  initial begin
    bit [31:0] edge_values[$];
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset tolerance, field extremes and exact squares
    edge_values = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'hFFFF_FFFF,
                    32'h0001_0000, 32'h0004_0000, 32'h0002_0000, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'hFFFF_0000, 32'h0000_0100, 32'h0000_8000,
                    32'h0009_0000, 32'h1234_5678};
    foreach (edge_values[i]) transfer_operand(edge_values[i]);

    write_tolerance(16'hFFFF);
    transfer_operand(32'h0000_0000);
    transfer_operand(32'hFFFF_FFFF);
    transfer_operand(32'h0000_0001);
    transfer_operand(32'h0001_0000);
    random_burst(20);

    // zero tolerance runs to the pass cap except for a zero operand
    write_tolerance(16'h0000);
    transfer_operand(32'h0000_0000);
    transfer_operand(32'h0001_0000);
    transfer_operand(32'hFFFF_FFFF);
    transfer_operand(32'h0000_0001);
    random_burst(4);

    write_tolerance(16'h0001);
    random_burst(10);

    write_tolerance(nsr_pkg::TOL_RESET);
    random_burst(40);

    for (int ph = 0; ph < 5; ph++) begin
      if (ph % 2 == 0)
        write_tolerance(16'($urandom_range(2, 64)));
      else
        write_tolerance(16'($urandom_range(65, 65535)));
      quiet = (ph == 2);
      random_burst(82);
    end
    quiet = 1'b0;

    wait_drained();
    repeat (60) @(posedge clk);
    sb.finish();
    if (sb.failures == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end
endmodule
